// ----- rtl/lpm_pkg.sv -----
// -----------------------------------------------------------------------------
// lpm_pkg
// Shared widths, codes, item record and helpers for the prefix match table.
// -----------------------------------------------------------------------------
package lpm_pkg;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 6;
	localparam int PORT_W     = 3;
	localparam int ENABLE_W   = 8;
	localparam int PORT_COUNT = 8;

	typedef enum logic {
		MODE_ADD    = 1'b0,
		MODE_LOOKUP = 1'b1
	} mode_t;

	// word travelling down the cell chain
	// add:    addr = network, len/port = route, accepted = slot granted
	// lookup: addr = destination, len/port/found = best match so far
	typedef struct packed {
		mode_t               mode;
		logic                accepted;
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    len;
		logic [PORT_W-1:0]   port;
		logic                found;
	} lpm_item_t;

	// all ones in the top len bits; len is at most ADDR_W here
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		prefix_mask = ~({ADDR_W{1'b1}} >> len);
	endfunction

	function automatic logic port_usable(input logic [ENABLE_W-1:0] enable,
			input logic [PORT_W-1:0] port);
		port_usable = (int'(port) < PORT_COUNT) && enable[port];
	endfunction

endpackage

// ----- rtl/lpm_in_if.sv -----
// -----------------------------------------------------------------------------
// lpm_in_if
// Request channel: route add or destination lookup word.
// -----------------------------------------------------------------------------
interface lpm_in_if
	import lpm_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                mode;
	logic [ADDR_W-1:0]   route_network;
	logic [LEN_W-1:0]    route_length;
	logic [PORT_W-1:0]   route_port;
	logic [ADDR_W-1:0]   dest_address;

	modport source (output valid, mode, route_network, route_length, route_port,
		dest_address, input ready);
	modport sink (input valid, mode, route_network, route_length, route_port,
		dest_address, output ready);
endinterface

// ----- rtl/lpm_out_if.sv -----
// -----------------------------------------------------------------------------
// lpm_out_if
// Result channel: one word per request.
// -----------------------------------------------------------------------------
interface lpm_out_if
	import lpm_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [PORT_W-1:0]   out_port;
	logic                route_found;
	logic                entry_accepted;

	modport source (output valid, out_port, route_found, entry_accepted, input ready);
	modport sink (input valid, out_port, route_found, entry_accepted, output ready);
endinterface

// ----- rtl/lpm_cfg_if.sv -----
// -----------------------------------------------------------------------------
// lpm_cfg_if
// Configuration write channel for the port enable register.
// -----------------------------------------------------------------------------
interface lpm_cfg_if
	import lpm_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [ENABLE_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/lpm_cell.sv -----
// -----------------------------------------------------------------------------
// lpm_cell
// One table slot of the chain: stores a route, claims an add aimed at it,
// and folds its route into every lookup that passes.
// -----------------------------------------------------------------------------
module lpm_cell
	import lpm_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  lpm_item_t       in_item,
	input  logic [CW-1:0]   in_cnt,
	output logic            out_valid,
	output lpm_item_t       out_item,
	output logic [CW-1:0]   out_cnt
);

	logic [ADDR_W-1:0] net_q;
	logic [LEN_W-1:0]  len_q;
	logic [PORT_W-1:0] port_q;

	logic              valid_q;
	lpm_item_t         item_q;
	logic [CW-1:0]     cnt_q;

	logic              live;
	logic              hit;
	logic              wr;
	lpm_item_t         nxt;

	// slot is populated for this word when it was stored before the word entered
	assign live = in_cnt > CW'(INDEX);
	assign hit  = ((in_item.addr ^ net_q) & prefix_mask(len_q)) == '0;
	assign wr   = adv && in_valid && in_item.mode == MODE_ADD && in_item.accepted
		&& in_cnt == CW'(INDEX);

	always_comb begin
		nxt = in_item;
		// later slot is newer, so ties go to it
		if (in_item.mode == MODE_LOOKUP && live && hit
				&& (!in_item.found || len_q >= in_item.len)) begin
			nxt.found = 1'b1;
			nxt.len   = len_q;
			nxt.port  = port_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			net_q  <= in_item.addr;
			len_q  <= in_item.len;
			port_q <= in_item.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
			cnt_q  <= in_cnt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;
	assign out_cnt   = cnt_q;

endmodule

// ----- rtl/longest_prefix_match_table.sv -----
// -----------------------------------------------------------------------------
// longest_prefix_match_table
// IPv4 route table with longest prefix match, built as a chain of slot cells.
//
//   channel | dir | word
//   --------+-----+----------------------------------------------------------
//   req     | in  | mode, route_network, route_length, route_port, dest_address
//   rsp     | out | out_port, route_found, entry_accepted
//   cfg     | in  | data = port enable mask
//
// A word can enter each cycle and moves down the chain cell by cell, register by register;
// throughput is one word per cycle when not stalled, set by the stage registers.
// The last cell's register is the result register; when it holds an untaken
// result the whole chain holds and req.ready drops.
// Reset empties the table at once (fill count to zero); no clearing pass.
// -----------------------------------------------------------------------------
module longest_prefix_match_table
	import lpm_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lpm_in_if.sink     req,
	lpm_out_if.source  rsp,
	lpm_cfg_if.sink    cfg
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [ENABLE_W-1:0] enable_q;
	logic [CW-1:0]       cnt_q;
	logic                adv;
	logic                take_add;
	logic [LEN_W-1:0]    sat_len;
	lpm_item_t           head_item;

	logic                v [TABLE_ENTRIES+1];
	lpm_item_t           it [TABLE_ENTRIES+1];
	logic [CW-1:0]       c [TABLE_ENTRIES+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg.valid) begin
			enable_q <= cfg.data;
		end
	end

	assign adv       = !v[TABLE_ENTRIES] || rsp.ready;
	assign req.ready = adv;

	assign sat_len  = (req.route_length > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : req.route_length;
	assign take_add = mode_t'(req.mode) == MODE_ADD && port_usable(enable_q, req.route_port)
		&& cnt_q < CW'(TABLE_ENTRIES);

	// fill count doubles as the slot number of the next add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.valid && adv && take_add) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_comb begin
		head_item.mode     = mode_t'(req.mode);
		head_item.accepted = take_add;
		head_item.found    = 1'b0;
		if (mode_t'(req.mode) == MODE_ADD) begin
			head_item.addr = req.route_network;
			head_item.len  = sat_len;
			head_item.port = req.route_port;
		end else begin
			head_item.addr = req.dest_address;
			head_item.len  = '0;
			head_item.port = '0;
		end
	end

	assign it[0] = head_item;
	assign v[0]  = req.valid;
	assign c[0]  = cnt_q;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		lpm_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (v[i]),
			.in_item   (it[i]),
			.in_cnt    (c[i]),
			.out_valid (v[i+1]),
			.out_item  (it[i+1]),
			.out_cnt   (c[i+1])
		);
	end

	assign rsp.valid          = v[TABLE_ENTRIES];
	assign rsp.route_found    = it[TABLE_ENTRIES].mode == MODE_LOOKUP && it[TABLE_ENTRIES].found;
	assign rsp.out_port       = rsp.route_found ? it[TABLE_ENTRIES].port : '0;
	assign rsp.entry_accepted = it[TABLE_ENTRIES].mode == MODE_ADD
		&& it[TABLE_ENTRIES].accepted;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_ENTRIES))
		else $error("fill count past table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && take_add) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("granted add did not take a slot");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.valid && req.ready && take_add) |=> cnt_q == $past(cnt_q))
		else $error("fill count moved without an add");

	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.route_found && rsp.entry_accepted))
		else $error("result flags both set");

endmodule

// ----- verif/longest_prefix_match_table_tb.sv -----
// -----------------------------------------------------------------------------
// longest_prefix_match_table_tb
// Self-checking bench for the prefix match table: route adds and lookups are
// driven over the request channel and predicted by a shadow route table; every
// result word is compared field by field, under random idling on both sides,
// a long result hold-off that backs up the chain, and several enable masks.
// -----------------------------------------------------------------------------
module longest_prefix_match_table_tb
	import lpm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 64;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = SLOTS + 16;
	localparam int MAX_REPORTS  = 20;

	typedef struct {
		mode_t               mode;
		logic [ADDR_W-1:0]   net;
		logic [LEN_W-1:0]    len;
		logic [PORT_W-1:0]   port;
		logic [ADDR_W-1:0]   dest;
	} route_req_t;

	typedef struct {
		logic [PORT_W-1:0]   port;
		logic                found;
		logic                accepted;
	} route_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lpm_in_if  req ();
	lpm_out_if rsp ();
	lpm_cfg_if cfg ();

	longest_prefix_match_table #(.TABLE_ENTRIES(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow route table
	logic [ADDR_W-1:0]   slot_net  [SLOTS];
	logic [LEN_W-1:0]    slot_len  [SLOTS];
	logic [PORT_W-1:0]   slot_port [SLOTS];
	int                  route_count;
	logic [ENABLE_W-1:0] port_enable;

	route_req_t    pending_words [$];
	route_result_t expected_results [$];
	route_req_t    offered;
	route_result_t want;

	int words_queued, results_seen, fail_count, cycle_count;
	int adds_ok, adds_refused, over_length, lookup_hits, lookup_misses, mask_writes;
	bit burst, hold_request;
	logic long_hold;
	int unsigned gap_left, stall_left, hold_next;

	function automatic logic [ADDR_W-1:0] prefix_bits(input logic [LEN_W-1:0] len);
		return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
	endfunction

	function automatic int unsigned draw_wait();
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
	endfunction

	// updates the shadow table and returns the word the block must answer with
	function automatic route_result_t apply_route_word(input route_req_t w);
		route_result_t       r;
		logic [LEN_W-1:0]    len;
		logic [LEN_W-1:0]    best_len;
		logic [ADDR_W-1:0]   m;
		r = '{default: '0};
		best_len = '0;
		if (w.mode == MODE_ADD) begin
			len = (w.len > ADDR_W) ? LEN_W'(ADDR_W) : w.len;
			if (w.len > ADDR_W)
				over_length++;
			if (int'(w.port) < PORT_COUNT && port_enable[w.port] && route_count < SLOTS) begin
				slot_net[route_count]  = w.net;
				slot_len[route_count]  = len;
				slot_port[route_count] = w.port;
				route_count++;
				r.accepted = 1'b1;
				adds_ok++;
			end else begin
				adds_refused++;
			end
		end else begin
			// later slots are newer, so >= lets the newest equal-length route win
			for (int i = 0; i < route_count; i++) begin
				m = prefix_bits(slot_len[i]);
				if ((w.dest & m) == (slot_net[i] & m) && (!r.found || slot_len[i] >= best_len)) begin
					r.found  = 1'b1;
					r.port   = slot_port[i];
					best_len = slot_len[i];
				end
			end
			if (r.found)
				lookup_hits++;
			else
				lookup_misses++;
		end
		return r;
	endfunction

	function automatic route_req_t rand_add();
		route_req_t        w;
		int unsigned       k;
		logic [ADDR_W-1:0] m;
		w.mode = MODE_ADD;
		w.dest = $urandom;
		w.port = $urandom_range(0, 7);
		// length 0 stays out: a stored default route would hide every miss
		w.len  = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 32);
		w.net  = $urandom;
		if (route_count > 0) begin
			k = $urandom_range(0, route_count - 1);
			case ($urandom_range(0, 2))
				0: begin
					w.net = slot_net[k];
					w.len = slot_len[k];
				end
				1: begin
					m = prefix_bits(slot_len[k]);
					w.net = (slot_net[k] & m) | ($urandom & ~m);
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic route_req_t rand_lookup();
		route_req_t        w;
		int unsigned       k;
		logic [ADDR_W-1:0] m;
		w.mode = MODE_LOOKUP;
		w.net  = $urandom;
		w.len  = $urandom_range(0, 63);
		w.port = $urandom_range(0, 7);
		w.dest = $urandom;
		if (route_count > 0 && $urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, route_count - 1);
			m = prefix_bits(slot_len[k]);
			w.dest = (slot_net[k] & m) | ($urandom & ~m);
		end
		return w;
	endfunction

	task automatic post_word(input route_req_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic post_add(input logic [ADDR_W-1:0] net, input logic [LEN_W-1:0] len,
			input logic [PORT_W-1:0] port);
		route_req_t w;
		w.mode = MODE_ADD;
		w.net  = net;
		w.len  = len;
		w.port = port;
		w.dest = $urandom;
		post_word(w);
	endtask

	task automatic post_lookup(input logic [ADDR_W-1:0] dest);
		route_req_t w;
		w.mode = MODE_LOOKUP;
		w.net  = $urandom;
		w.len  = $urandom_range(0, 63);
		w.port = $urandom_range(0, 7);
		w.dest = dest;
		post_word(w);
	endtask

	task automatic queue_traffic(input int n, input int add_pct);
		for (int i = 0; i < n; i++)
			post_word(($urandom_range(0, 99) < add_pct) ? rand_add() : rand_lookup());
	endtask

	task automatic wait_idle();
		while (results_seen != words_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(input logic [ENABLE_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid   <= 1'b0;
		port_enable = v;
		mask_writes++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid         <= 1'b0;
			req.mode          <= MODE_ADD;
			req.route_network <= '0;
			req.route_length  <= '0;
			req.route_port    <= '0;
			req.dest_address  <= '0;
			gap_left          <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_results.push_back(apply_route_word(offered));
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					req.valid <= 1'b0;
					gap_left  <= gap_left - 1;
				end else if (pending_words.size() > 0) begin
					offered = pending_words.pop_front();
					req.mode          <= offered.mode;
					req.route_network <= offered.net;
					req.route_length  <= offered.len;
					req.route_port    <= offered.port;
					req.dest_address  <= offered.dest;
					req.valid         <= 1'b1;
					// keep offering back to back in burst mode or while the result side is held off
					gap_left <= (burst || long_hold) ? 0 : draw_wait();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			stall_left <= 0;
			long_hold  <= 1'b0;
		end else begin
			hold_next = stall_left;
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected result word port=%0d found=%0b accepted=%0b",
							$time, rsp.out_port, rsp.route_found, rsp.entry_accepted);
				end else begin
					want = expected_results.pop_front();
					if (rsp.out_port !== want.port || rsp.route_found !== want.found ||
							rsp.entry_accepted !== want.accepted) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"%0t: result mismatch, expected port=%0d found=%0b ",
								"accepted=%0b, got port=%0d found=%0b accepted=%0b"},
								$time, want.port, want.found, want.accepted,
								rsp.out_port, rsp.route_found, rsp.entry_accepted);
					end
				end
				results_seen++;
				hold_next = burst ? 0 : draw_wait();
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_next    = HOLD_CYCLES;
				long_hold   <= 1'b1;
			end else if (hold_next == 0) begin
				long_hold <= 1'b0;
			end
			if (hold_next > 0) begin
				rsp.ready  <= 1'b0;
				stall_left <= hold_next - 1;
			end else begin
				rsp.ready  <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d of %0d results seen", $time, results_seen, words_queued);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		cfg.valid    <= 1'b0;
		cfg.data     <= '0;
		port_enable  = '0;
		route_count  = 0;
		burst        = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ports 0, 2, 5 and 7 enabled
		write_enable(8'hA5);
		post_lookup(32'h0000_0000);                 // empty table
		post_add(32'hFFFF_FFFF, 6'd32, 3'd0);
		post_add(32'hC0A8_0000, 6'd16, 3'd2);
		post_add(32'hC0A8_0100, 6'd24, 3'd5);
		post_add(32'hC0A8_0100, 6'd24, 3'd0);       // same prefix, newer one wins
		post_add(32'h0A00_0001, 6'd63, 3'd2);       // over-length, saturates
		post_add(32'h0A00_0002, 6'd33, 3'd5);
		post_add(32'h8000_0000, 6'd1, 3'd5);
		post_add(32'h0000_0000, 6'd0, 3'd1);        // disabled port
		post_add(32'h0102_0300, 6'd24, 3'd3);
		post_add(32'h0102_0300, 6'd24, 3'd4);
		post_add(32'h0102_0300, 6'd24, 3'd6);
		post_lookup(32'hFFFF_FFFF);
		post_lookup(32'hC0A8_01FE);
		post_lookup(32'hC0A8_FF01);
		post_lookup(32'h0A00_0001);
		post_lookup(32'h0A00_0002);
		post_lookup(32'h0A00_0003);
		post_lookup(32'h8000_0001);
		post_lookup(32'h0102_0304);
		post_lookup(32'h7FFF_FFFF);
		wait_idle();

		write_enable(8'h00);
		queue_traffic(60, 35);
		wait_idle();

		write_enable(8'hFF);
		queue_traffic(100, 20);
		wait_idle();

		write_enable(ENABLE_W'($urandom_range(1, 254)));
		burst = 1'b1;
		queue_traffic(140, 20);
		wait_idle();
		burst = 1'b0;

		write_enable(8'h01);
		queue_traffic(90, 20);
		wait_idle();

		// fill the table, store a default route in the last slot, then overflow
		write_enable(8'h80);
		for (int i = route_count; i < SLOTS - 1; i++)
			post_add($urandom, LEN_W'($urandom_range(1, 32)), 3'd7);
		post_add(32'h0000_0000, 6'd0, 3'd7);
		post_add($urandom, 6'd32, 3'd7);
		queue_traffic(130, 30);
		hold_request = 1'b1;
		wait_idle();

		write_enable(ENABLE_W'($urandom));
		queue_traffic(90, 40);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d words: %0d routes stored, %0d adds refused, %0d over-length",
			results_seen, adds_ok, adds_refused, over_length);
		$display("  %0d lookups hit, %0d missed, %0d mask writes, table at %0d of %0d slots",
			lookup_hits, lookup_misses, mask_writes, route_count, SLOTS);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lpm_pkg.sv
rtl/lpm_in_if.sv
rtl/lpm_out_if.sv
rtl/lpm_cfg_if.sv
rtl/lpm_cell.sv
rtl/longest_prefix_match_table.sv
verif/longest_prefix_match_table_tb.sv
